[rtl/core/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and round tables of the MD5 stream hasher
// Holds the initial chaining values, the round constants and shifts, the
// message word schedule and the front-to-back command item.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         BLK_BYTES  = 64;
  localparam int         POS_W      = 6;
  localparam int         LEN_POS    = 56;
  localparam int         QUEUE_DEPTH = 2;
  localparam int         IN_TDATA_W  = 16;
  localparam int         OUT_TDATA_W = 64;

  // one back-end job: a full block, with or without a following digest
  typedef struct packed {
    logic [511:0] blk;
    logic         emit;
  } md5_job_t;

  localparam int JOB_W = $bits(md5_job_t);

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    begin
      case ({i[5:4], i[1:0]})
        4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
        4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
        4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
        4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

  // message word index per round
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    logic [5:0] t;
    begin
      t = 6'd0;
      case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: begin
          t = (i << 2) + i + 6'd1;
          g = t[3:0];
        end
        2'd2: begin
          t = (i << 1) + i + 6'd5;
          g = t[3:0];
        end
        default: begin
          t = (i << 3) - i;
          g = t[3:0];
        end
      endcase
      return g;
    end
  endfunction

endpackage

[rtl/core/md5_front.sv]
// ----------------------------------------------------------------------------
// md5_front: byte intake and padding
// Packs bytes into a block, counts bits, and on end of message appends 0x80,
// zeros and the length, issuing one or two block jobs to the queue.
// ----------------------------------------------------------------------------
module md5_front
  import md5_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             has_byte,
  input  logic             end_of_message,
  output logic             job_valid,
  input  logic             job_ready,
  output md5_job_t         job
);

  typedef enum logic [2:0] {
    S_FILL = 3'b001,
    S_PAD1 = 3'b010,
    S_PAD2 = 3'b100
  } fst_t;

  fst_t          state_r, state_nxt;
  logic [511:0]  blk_r, blk_nxt;
  logic [63:0]   cnt_r, cnt_nxt;
  logic [63:0]   len_r, len_nxt;
  logic          eom_r, eom_nxt;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pp;
  logic [511:0]  pad_blk;
  logic [63:0]   cnt_b;

  assign pos = cnt_r[POS_W+2:3];
  assign in_ready = (state_r == S_FILL) && !job_valid;

  // padded block view of the buffer: bytes at/after pp are zeroed
  always_comb begin
    pad_blk = blk_r;
    for (int b = 0; b < BLK_BYTES; b++) begin
      if (b >= int'(pp)) pad_blk[8*b +: 8] = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    eom_nxt   = eom_r;
    job_valid = 1'b0;
    job       = '{blk: blk_r, emit: 1'b0};
    cnt_b     = cnt_r + 64'd8;
    pp        = pos;
    case (state_r)
      S_FILL: begin
        if (in_valid && in_ready) begin
          if (has_byte) begin
            blk_nxt[8*pos +: 8] = data_byte;
            cnt_nxt = cnt_b;
          end
          // a byte that closes the block goes out first, padding follows
          eom_nxt = end_of_message;
          if (has_byte && pos == POS_W'(BLK_BYTES-1)) state_nxt = S_PAD2;
          else if (end_of_message) state_nxt = S_PAD1;
          len_nxt = has_byte ? cnt_b : cnt_r;
        end
      end
      S_PAD1: begin
        // mark byte at current position; len_r holds the message length
        pp = pos;
        job_valid = 1'b1;
        if (pos >= POS_W'(LEN_POS)) begin
          job.blk = pad_blk;
          job.blk[8*pos +: 8] = PAD_BYTE;
          for (int b = 0; b < BLK_BYTES; b++)
            if (b > int'(pos)) job.blk[8*b +: 8] = 8'h00;
          job.emit = 1'b0;
          if (job_ready) begin
            blk_nxt = '0;
            cnt_nxt = {cnt_r[63:POS_W+3], {(POS_W+3){1'b0}}};
            len_nxt = len_r;
            state_nxt = S_PAD2;
            cnt_nxt[0] = 1'b1; // flag: 0x80 already placed
          end
        end else begin
          job.blk = pad_blk;
          job.blk[8*pos +: 8] = PAD_BYTE;
          job.blk[511:448] = len_r;
          job.emit = 1'b1;
          if (job_ready) begin
            blk_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_FILL;
          end
        end
      end
      default: begin
        // S_PAD2: full data block (mid message) or final length-only block
        job_valid = 1'b1;
        if (cnt_r[0]) begin
          job.blk = '0;
          job.blk[511:448] = len_r;
          job.emit = 1'b1;
          if (job_ready) begin
            blk_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_FILL;
          end
        end else begin
          job.blk = blk_r;
          job.emit = 1'b0;
          if (job_ready) state_nxt = eom_r ? S_PAD1 : S_FILL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      cnt_r   <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      eom_r   <= eom_nxt;
    end
    blk_r <= blk_nxt;
    len_r <= len_nxt;
  end

  // low count bits are only ever nonzero as the pad flag in S_PAD2
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] |-> state_r == S_PAD2)
    else $error("pad flag outside second pad block");

endmodule

[rtl/core/md5_queue.sv]
// ----------------------------------------------------------------------------
// md5_queue: short job queue between intake and compression
// Two-entry register FIFO.
// ----------------------------------------------------------------------------
module md5_queue
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  md5_job_t wr_job,
  output logic     rd_valid,
  input  logic     rd_ready,
  output md5_job_t rd_job
);

  md5_job_t   mem_r [QUEUE_DEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_job;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

[rtl/core/md5_back.sv]
// ----------------------------------------------------------------------------
// md5_back: iterative MD5 compression, one round per cycle, and digest output
// Runs 64 rounds per block job, adds back the chaining words, and on jobs
// that close a message presents the digest as two results.
// ----------------------------------------------------------------------------
module md5_back
  import md5_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  md5_job_t          job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RUN  = 4'b0010,
    B_OUT0 = 4'b0100,
    B_OUT1 = 4'b1000
  } bst_t;

  bst_t         state_r, state_nxt;
  logic [31:0]  h_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [511:0] w_r;
  logic         emit_r;
  logic [5:0]   rnd_r;
  logic [31:0]  f, sum, rot, nb, wg;
  logic [63:0]  p0, p1;

  assign job_ready = state_r == B_IDLE;

  always_comb begin
    case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    wg  = w_r[32*msg_idx(rnd_r) +: 32];
    sum = a_r + f + round_k(rnd_r) + wg;
    rot = (sum << rot_amt(rnd_r)) | (sum >> (6'd32 - {1'b0, rot_amt(rnd_r)}));
    nb  = b_r + rot;
  end

  // digest bytes: word k little-endian, first byte in top bits
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      p0[63-8*k -: 8] = h_r[k/4][8*(k%4) +: 8];
      p1[63-8*k -: 8] = h_r[2+k/4][8*(k%4) +: 8];
    end
  end

  assign out_tvalid = (state_r == B_OUT0) || (state_r == B_OUT1);
  assign out_tdata  = (state_r == B_OUT1) ? p1 : p0;
  assign out_tuser  = {1'b0, state_r == B_OUT1};
  assign out_tlast  = state_r == B_OUT1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (job_valid) state_nxt = B_RUN;
      B_RUN:  if (rnd_r == 6'd63) state_nxt = emit_r ? B_OUT0 : B_IDLE;
      B_OUT0: if (out_tready) state_nxt = B_OUT1;
      B_OUT1: if (out_tready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
      rnd_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_IDLE: rnd_r <= '0;
        B_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            h_r[0] <= h_r[0] + d_r;
            h_r[1] <= h_r[1] + nb;
            h_r[2] <= h_r[2] + b_r;
            h_r[3] <= h_r[3] + c_r;
          end
        end
        B_OUT1: if (out_tready) begin
          h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
        end
        default: ;
      endcase
    end
    if (state_r == B_IDLE) begin
      w_r <= job.blk; emit_r <= job.emit;
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
    end else if (state_r == B_RUN) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= nb;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && rnd_r == 6'd63 && !emit_r) |=> state_r == B_IDLE)
    else $error("non-final block did not return to idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT0 && out_tready) |=> state_r == B_OUT1)
    else $error("second digest half skipped");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> out_tuser[0])
    else $error("last part without index one");

endmodule

[rtl/core/md5_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// md5_stream_hasher_top: MD5 (RFC 1321) hasher over a byte stream
// Intake front, two-entry block queue, iterative compression back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction per item. in_tdata[7:0] is the
//   message byte, in_tdata[8] says whether the byte is valid, in_tlast marks
//   the final item of a message (it may carry no byte: empty messages work).
//   Output channel out_*: two transactions per message, the digest bytes
//   0-7 then 8-15 in out_tdata (first byte in bits 63:56); out_tuser[0] is
//   the part index, out_tlast flags the second part.
//   Throughput: a byte per cycle while a block fills; each full block then
//   runs through the round unit at one MD5 round per cycle. The queue
//   holds two blocks, so intake of the next block overlaps compression until
//   the queue fills; the round unit takes a new block only once it is back
//   in idle after the last one.
//   The digest follows compression of the message's final block job; when the
//   padding spills into an extra block or the last byte closes a block, the
//   message ends in two block jobs.
//   Reset (rst_n low, synchronous) restores the initial chaining values and
//   a zero bit count. A stalled out_tready holds the digest and back-pressures
//   through the queue to in_tready; nothing is dropped.
// ----------------------------------------------------------------------------
module md5_stream_hasher_top
  import md5_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte, [8] has_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] digest_part
  output logic [1:0]             out_tuser,  // [0] part_index, [1] zero
  output logic                   out_tlast
);

  md5_job_t fj, bj;
  logic     fv, fr, bv, br;

  md5_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata[7:0]), .has_byte(in_tdata[8]), .end_of_message(in_tlast),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  md5_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(bv), .rd_ready(br), .rd_job(bj)
  );

  md5_back u_back (
    .clk, .rst_n,
    .job_valid(bv), .job_ready(br), .job(bj),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule
